// ===== sv/tksl_pkg.sv =====
// ----------------------------------------------------------------------------
// tksl_pkg
// Shared types and constants for the top-K sorted insertion list.
// ----------------------------------------------------------------------------
package tksl_pkg;

    localparam int ID_W    = 16;
    localparam int FREQ_W  = 24;
    localparam int SCORE_W = 32;
    localparam int RIDX_W  = 4;
    localparam int SLOT_W  = 4;

    // Q16.16 value of -1.0
    localparam logic signed [SCORE_W-1:0] SCORE_RESET = 32'shFFFF_0000;

    // Command codes on the command input
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS,
        ST_READ
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic compare;
        logic write_list;
        logic load_ins_res;
        logic load_rd_res;
    } dp_cmd_t;

endpackage

// ===== sv/tksl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tksl_ctrl
// Sequencer for the top-K list: accepts a transaction, steps the datapath
// through compare and update or read, then pulses done for one cycle.
// ----------------------------------------------------------------------------
module tksl_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    output logic             busy,
    output logic             done,
    output tksl_pkg::dp_cmd_t cmd
);
    import tksl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_READ)
                        state_next = ST_READ;
                    else
                        state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_INS;
            ST_INS:  state_next = ST_IDLE;
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs to the datapath
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: cmd.load_in = start;
            ST_CMP:  cmd.compare = 1'b1;
            ST_INS:
            begin
                cmd.write_list   = 1'b1;
                cmd.load_ins_res = 1'b1;
            end
            ST_READ: cmd.load_rd_res = 1'b1;
            default: cmd = '0;
        endcase
    end

    // Raise done at the same edge that registers the result
    assign done_next = (state_reg == ST_INS) || (state_reg == ST_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== sv/tksl_datapath.sv =====
// ----------------------------------------------------------------------------
// tksl_datapath
// Row of list cells with per-cell score compare, shift-down insert, read
// select and result registers.
// ----------------------------------------------------------------------------
module tksl_datapath #(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tksl_pkg::dp_cmd_t                     cmd,
    input  logic [tksl_pkg::ID_W-1:0]             new_word_id,
    input  logic [tksl_pkg::FREQ_W-1:0]           new_frequency,
    input  logic signed [tksl_pkg::SCORE_W-1:0]   new_score,
    input  logic [tksl_pkg::RIDX_W-1:0]           read_index,
    output logic                                  inserted,
    output logic [tksl_pkg::SLOT_W-1:0]           insert_slot,
    output logic [tksl_pkg::ID_W-1:0]             entry_word_id,
    output logic [tksl_pkg::FREQ_W-1:0]           entry_frequency,
    output logic signed [tksl_pkg::SCORE_W-1:0]   entry_score
);
    import tksl_pkg::*;

    // Latched transaction
    logic [ID_W-1:0]           wid_reg;
    logic [FREQ_W-1:0]         freq_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [RIDX_W-1:0]         ridx_reg;

    // List cells
    logic signed [SCORE_W-1:0] slot_score_reg  [LIST_DEPTH];
    logic signed [SCORE_W-1:0] slot_score_next [LIST_DEPTH];
    logic [ID_W-1:0]           slot_wid_reg    [LIST_DEPTH];
    logic [ID_W-1:0]           slot_wid_next   [LIST_DEPTH];
    logic [FREQ_W-1:0]         slot_freq_reg   [LIST_DEPTH];
    logic [FREQ_W-1:0]         slot_freq_next  [LIST_DEPTH];

    // Compare flags: thermometer, set from the insert point down
    logic [LIST_DEPTH-1:0] gt_reg;
    logic [LIST_DEPTH-1:0] gt_next;
    logic [LIST_DEPTH-1:0] first_hot;
    logic [SLOT_W-1:0]     slot_enc;

    // Result registers
    logic                      inserted_reg,  inserted_next;
    logic [SLOT_W-1:0]         slot_reg,      slot_next;
    logic [ID_W-1:0]           rd_wid_reg,    rd_wid_next;
    logic [FREQ_W-1:0]         rd_freq_reg,   rd_freq_next;
    logic signed [SCORE_W-1:0] rd_score_reg,  rd_score_next;
    logic [ID_W-1:0]           sel_wid;
    logic [FREQ_W-1:0]         sel_freq;
    logic signed [SCORE_W-1:0] sel_score;

    // Capture the transaction on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            wid_reg   <= new_word_id;
            freq_reg  <= new_frequency;
            score_reg <= new_score;
            ridx_reg  <= read_index;
        end
    end

    // Per-cell compare, shift and insert
    for (genvar k = 0; k < LIST_DEPTH; k++)
    begin : g_cell
        assign gt_next[k] = (score_reg > slot_score_reg[k]);

        if (k == 0)
        begin : g_head
            assign first_hot[k] = gt_reg[k];

            always_comb
            begin
                slot_score_next[k] = slot_score_reg[k];
                slot_wid_next[k]   = slot_wid_reg[k];
                slot_freq_next[k]  = slot_freq_reg[k];
                if (cmd.write_list && gt_reg[k])
                begin
                    slot_score_next[k] = score_reg;
                    slot_wid_next[k]   = wid_reg;
                    slot_freq_next[k]  = freq_reg;
                end
            end
        end
        else
        begin : g_body
            assign first_hot[k] = gt_reg[k] & ~gt_reg[k-1];

            always_comb
            begin
                slot_score_next[k] = slot_score_reg[k];
                slot_wid_next[k]   = slot_wid_reg[k];
                slot_freq_next[k]  = slot_freq_reg[k];
                if (cmd.write_list && gt_reg[k-1])
                begin
                    // shift down from the cell above
                    slot_score_next[k] = slot_score_reg[k-1];
                    slot_wid_next[k]   = slot_wid_reg[k-1];
                    slot_freq_next[k]  = slot_freq_reg[k-1];
                end
                else if (cmd.write_list && gt_reg[k])
                begin
                    slot_score_next[k] = score_reg;
                    slot_wid_next[k]   = wid_reg;
                    slot_freq_next[k]  = freq_reg;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slot_score_reg[k] <= SCORE_RESET;
                slot_wid_reg[k]   <= '0;
                slot_freq_reg[k]  <= '0;
            end
            else
            begin
                slot_score_reg[k] <= slot_score_next[k];
                slot_wid_reg[k]   <= slot_wid_next[k];
                slot_freq_reg[k]  <= slot_freq_next[k];
            end
        end
    end

    // Hold compare flags for the update cycle
    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            gt_reg <= gt_next;
        end
    end

    // Encode the insert point (low bits of the slot number)
    always_comb
    begin
        slot_enc = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            if (first_hot[k])
                slot_enc = slot_enc | SLOT_W'(k);
        end
    end

    // Select the slot to read; an index past the list reads as zero
    always_comb
    begin
        sel_wid   = '0;
        sel_freq  = '0;
        sel_score = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            if (int'(ridx_reg) == k)
            begin
                sel_wid   = slot_wid_reg[k];
                sel_freq  = slot_freq_reg[k];
                sel_score = slot_score_reg[k];
            end
        end
    end

    // Load the result
    always_comb
    begin
        inserted_next = inserted_reg;
        slot_next     = slot_reg;
        rd_wid_next   = rd_wid_reg;
        rd_freq_next  = rd_freq_reg;
        rd_score_next = rd_score_reg;
        if (cmd.load_ins_res)
        begin
            inserted_next = |gt_reg;
            slot_next     = slot_enc;
            rd_wid_next   = '0;
            rd_freq_next  = '0;
            rd_score_next = '0;
        end
        else if (cmd.load_rd_res)
        begin
            inserted_next = 1'b0;
            slot_next     = '0;
            rd_wid_next   = sel_wid;
            rd_freq_next  = sel_freq;
            rd_score_next = sel_score;
        end
    end

    always_ff @(posedge clk)
    begin
        inserted_reg <= inserted_next;
        slot_reg     <= slot_next;
        rd_wid_reg   <= rd_wid_next;
        rd_freq_reg  <= rd_freq_next;
        rd_score_reg <= rd_score_next;
    end

    assign inserted        = inserted_reg;
    assign insert_slot     = slot_reg;
    assign entry_word_id   = rd_wid_reg;
    assign entry_frequency = rd_freq_reg;
    assign entry_score     = rd_score_reg;

endmodule

// ===== sv/top_k_sorted_insert_list_unit.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list_unit
// Top-K list of scored words kept in descending score order.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An insert
// (command 0) then holds busy while it compares against every slot in
// parallel, registers the compare flags, then shifts and writes the list.
// A read (command 1) holds busy while it selects the slot. The result
// appears on the output ports for exactly one cycle with done high, in the
// first cycle that busy is low again, so the receiver must take it then; a
// new start may be given in that same cycle. No new transaction is taken
// while busy is high, so each must finish before the next is accepted.
// After reset every slot holds id 0, frequency 0, score -1.0.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list_unit #(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    output logic                                  done,
    input  logic                                  command,
    input  logic [tksl_pkg::ID_W-1:0]             new_word_id,
    input  logic [tksl_pkg::FREQ_W-1:0]           new_frequency,
    input  logic signed [tksl_pkg::SCORE_W-1:0]   new_score,
    input  logic [tksl_pkg::RIDX_W-1:0]           read_index,
    output logic                                  inserted,
    output logic [tksl_pkg::SLOT_W-1:0]           insert_slot,
    output logic [tksl_pkg::ID_W-1:0]             entry_word_id,
    output logic [tksl_pkg::FREQ_W-1:0]           entry_frequency,
    output logic signed [tksl_pkg::SCORE_W-1:0]   entry_score
);
    import tksl_pkg::*;

    dp_cmd_t dp_cmd;

    // Sequencer
    tksl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .cmd     (dp_cmd)
    );

    // List storage and result path
    tksl_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .new_word_id     (new_word_id),
        .new_frequency   (new_frequency),
        .new_score       (new_score),
        .read_index      (read_index),
        .inserted        (inserted),
        .insert_slot     (insert_slot),
        .entry_word_id   (entry_word_id),
        .entry_frequency (entry_frequency),
        .entry_score     (entry_score)
    );

endmodule
